### hw/rtl/pascal_token_scanner_top_macros.svh
// Assertion macros shared by the token scanner RTL.
`ifndef PASCAL_TOKEN_SCANNER_TOP_MACROS_SVH
`define PASCAL_TOKEN_SCANNER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pts_pkg.sv
// Package with types, character constants and scan functions of the token scanner.
package pts_pkg;

  localparam int LEN_BITS_DEFAULT = 16;
  localparam int Q_DEPTH_DEFAULT  = 4;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [8:0] BAD_EOI = 9'h100;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_ID      = 5'd1,
    ST_DEC     = 5'd2,
    ST_HEXS    = 5'd3,
    ST_HEX     = 5'd4,
    ST_OCTS    = 5'd5,
    ST_OCT     = 5'd6,
    ST_BINS    = 5'd7,
    ST_BIN     = 5'd8,
    ST_FRAC    = 5'd9,
    ST_EXPS    = 5'd10,
    ST_EXPSIGN = 5'd11,
    ST_EXP     = 5'd12,
    ST_STR     = 5'd13,
    ST_STRQ    = 5'd14,
    ST_CTRLS   = 5'd15,
    ST_CTRL    = 5'd16,
    ST_NONE    = 5'd31
  } scan_state_t;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_DEC    = 3'd1,
    KIND_HEX    = 3'd2,
    KIND_OCT    = 3'd3,
    KIND_BIN    = 3'd4,
    KIND_FLOAT  = 3'd5,
    KIND_STRING = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEX       = 3'd1,
    ERR_OCT       = 3'd2,
    ERR_BIN       = 3'd3,
    ERR_EXPONENT  = 3'd4,
    ERR_CONTROL   = 3'd5,
    ERR_UNTERM    = 3'd6,
    ERR_INVALID   = 3'd7
  } err_t;

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [15:0] len;
    logic [8:0]  bad;
  } res_t;

  typedef struct packed {
    logic second;
    res_t r0;
    res_t r1;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_exp_mark(input logic [7:0] c);
    return (c == CH_LOWER_E) || (c == CH_UPPER_E);
  endfunction

  function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
    scan_state_t ns;
    ns = ST_NONE;
    case (s)
      ST_ID: ns = (is_alpha(c) || is_digit(c)) ? ST_ID : ST_NONE;
      ST_DEC: begin
        if (is_digit(c)) ns = ST_DEC;
        else if (c == CH_DOT) ns = ST_FRAC;
        else if (is_exp_mark(c)) ns = ST_EXPS;
      end
      ST_HEXS, ST_HEX: ns = is_xdigit(c) ? ST_HEX : ST_NONE;
      ST_OCTS, ST_OCT: ns = ((c >= CH_ZERO) && (c <= CH_SEVEN)) ? ST_OCT : ST_NONE;
      ST_BINS, ST_BIN: ns = ((c == CH_ZERO) || (c == CH_ONE)) ? ST_BIN : ST_NONE;
      ST_FRAC: begin
        if (is_digit(c)) ns = ST_FRAC;
        else if (is_exp_mark(c)) ns = ST_EXPS;
      end
      ST_EXPS: begin
        if ((c == CH_PLUS) || (c == CH_MINUS)) ns = ST_EXPSIGN;
        else if (is_digit(c)) ns = ST_EXP;
      end
      ST_EXPSIGN, ST_EXP: ns = is_digit(c) ? ST_EXP : ST_NONE;
      ST_STR: begin
        if (c == CH_QUOTE) ns = ST_STRQ;
        else if (c != CH_NEWLINE) ns = ST_STR;
      end
      ST_STRQ: begin
        if (c == CH_HASH) ns = ST_CTRLS;
        else if (c == CH_QUOTE) ns = ST_STR;
      end
      ST_CTRLS: ns = is_digit(c) ? ST_CTRL : ST_NONE;
      ST_CTRL: begin
        if (is_digit(c)) ns = ST_CTRL;
        else if (c == CH_HASH) ns = ST_CTRLS;
        else if (c == CH_QUOTE) ns = ST_STR;
      end
      default: ns = ST_NONE;
    endcase
    return ns;
  endfunction

  function automatic err_t pending_error(input scan_state_t s);
    err_t e;
    case (s)
      ST_HEXS:             e = ERR_HEX;
      ST_OCTS:             e = ERR_OCT;
      ST_BINS:             e = ERR_BIN;
      ST_EXPS, ST_EXPSIGN: e = ERR_EXPONENT;
      ST_CTRLS:            e = ERR_CONTROL;
      ST_STR:              e = ERR_UNTERM;
      default:             e = ERR_NONE;
    endcase
    return e;
  endfunction

  function automatic scan_state_t start_state(input logic [7:0] c);
    scan_state_t s;
    priority if (is_alpha(c)) s = ST_ID;
    else if (is_digit(c))     s = ST_DEC;
    else if (c == CH_DOLLAR)  s = ST_HEXS;
    else if (c == CH_AMP)     s = ST_OCTS;
    else if (c == CH_PERCENT) s = ST_BINS;
    else if (c == CH_QUOTE)   s = ST_STR;
    else if (c == CH_HASH)    s = ST_CTRLS;
    else                      s = ST_IDLE;
    return s;
  endfunction

  function automatic kind_t start_kind(input scan_state_t s);
    kind_t k;
    case (s)
      ST_DEC:             k = KIND_DEC;
      ST_HEXS:            k = KIND_HEX;
      ST_OCTS:            k = KIND_OCT;
      ST_BINS:            k = KIND_BIN;
      ST_STR, ST_CTRLS:   k = KIND_STRING;
      default:            k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/pascal_token_scanner_top.sv
// Top level of the Pascal token scanner: front end, group queue and output stage.
// Usage:
//   The input channel takes one beat per source byte on in_ch, or an end-of-input
//   beat with in_end_of_input high, which flushes any pending token.
//   A beat is taken at a rising edge with in_valid high and in_stall low.
//   Each input beat causes zero, one or two result beats on the output channel,
//   taken at an edge with out_valid high and out_stall low; out_last marks the
//   final result of one input beat.
//   A result passes through the group queue and the output stage register before
//   it appears on the outputs, and it waits there while the output stage is busy.
//   The scanner takes one input byte per cycle while in_stall is low; the output
//   stage sends one result beat per cycle while out_stall is low, so a byte that
//   causes two results sends them on the output channel one after the other.
//   A four-group queue sits between the scanner and the output stage; in_stall
//   rises only when that queue is full, which happens when results leave slower than bytes arrive.
//   Reset (rst_n low at a clock edge) returns the scanner to its start state and
//   empties the queue and the output stage.
`include "pascal_token_scanner_top_macros.svh"

module pascal_token_scanner_top import pts_pkg::*; #(
  parameter int LENGTH_BITS = LEN_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_token_length,
  output logic [8:0]  out_bad_char,
  output logic        out_last
);

  logic    in_acc;
  logic    grp_push, q_push, q_pop;
  grp_t    front_grp, q_head;
  q_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = in_acc && grp_push;

  pts_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .ch   (in_ch),
    .eoi  (in_end_of_input),
    .push (grp_push),
    .grp  (front_grp)
  );

  pts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(front_grp),
    .pop  (q_pop),
    .rdata(q_head),
    .stat (q_stat)
  );

  pts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .qs              (q_stat),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_error_code  (out_error_code),
    .out_token_length(out_token_length),
    .out_bad_char    (out_bad_char),
    .out_last        (out_last)
  );

  `PTS_ASSERT_SAME(a_no_overflow, q_push, !q_stat.full, "Queue written while full.")
  `PTS_ASSERT_SAME(a_first_is_token, out_valid && !out_last, (out_error_code == ERR_NONE) && (out_kind != KIND_ERROR), "First of two results is not a token.")
  `PTS_ASSERT_SAME(a_error_has_code, out_valid && (out_kind == KIND_ERROR), out_error_code != ERR_NONE, "Error result without an error code.")
  `PTS_ASSERT_SAME(a_token_clean, out_valid && (out_kind != KIND_ERROR), (out_error_code == ERR_NONE) && (out_bad_char == 9'h000), "Token result carries error fields.")

endmodule

### hw/rtl/pts_front.sv
// Front end: accepts characters, runs the scan state machine and forms result groups.
module pts_front import pts_pkg::*; #(
  parameter int LENGTH_BITS = LEN_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] ch,
  input  logic       eoi,
  output logic       push,
  output grp_t       grp
);

  scan_state_t            state_r, state_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  logic [LENGTH_BITS+15:0] len_ext;
  logic [15:0]             len16;

  assign len_ext = {16'h0000, len_r};
  assign len16   = len_ext[15:0];

  always_comb begin
    scan_state_t ns;
    scan_state_t ss;
    logic        start;
    ns        = next_state(state_r, ch);
    ss        = start_state(ch);
    start     = 1'b1;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    if (eoi) begin
      state_nxt = ST_IDLE;
      kind_nxt  = KIND_IDENT;
      len_nxt   = '0;
    end else begin
      if (state_r != ST_IDLE) begin
        if (ns != ST_NONE) begin
          start     = 1'b0;
          state_nxt = ns;
          if ((ns == ST_FRAC) || (ns == ST_EXPS)) kind_nxt = KIND_FLOAT;
          if (len_r != '1) len_nxt = len_r + LENGTH_BITS'(1);
        end else begin
          state_nxt = ST_IDLE;
          kind_nxt  = KIND_IDENT;
          len_nxt   = '0;
          if (pending_error(state_r) != ERR_NONE) start = 1'b0;
        end
      end
      if (start) begin
        state_nxt = ss;
        kind_nxt  = start_kind(ss);
        len_nxt   = (ss == ST_IDLE) ? '0 : LENGTH_BITS'(1);
      end
    end
  end

  always_comb begin
    scan_state_t ns;
    err_t        code;
    logic        start;
    res_t        inval;
    ns          = next_state(state_r, ch);
    code        = pending_error(state_r);
    start       = 1'b1;
    push        = 1'b0;
    grp         = '0;
    inval.kind  = KIND_ERROR;
    inval.code  = ERR_INVALID;
    inval.len   = 16'h0000;
    inval.bad   = {1'b0, ch};
    if (eoi) begin
      if (state_r != ST_IDLE) begin
        push = 1'b1;
        if (code != ERR_NONE) begin
          grp.r0 = '{kind: KIND_ERROR, code: code, len: len16, bad: BAD_EOI};
        end else begin
          grp.r0 = '{kind: kind_r, code: ERR_NONE, len: len16, bad: 9'h000};
        end
      end
    end else begin
      if (state_r != ST_IDLE) begin
        if (ns != ST_NONE) begin
          start = 1'b0;
        end else if (code != ERR_NONE) begin
          start  = 1'b0;
          push   = 1'b1;
          grp.r0 = '{kind: KIND_ERROR, code: code, len: len16, bad: {1'b0, ch}};
        end else begin
          push   = 1'b1;
          grp.r0 = '{kind: kind_r, code: ERR_NONE, len: len16, bad: 9'h000};
        end
      end
      if (start && (start_state(ch) == ST_IDLE)) begin
        if (push) begin
          grp.second = 1'b1;
          grp.r1     = inval;
        end else begin
          push   = 1'b1;
          grp.r0 = inval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_IDENT;
      len_r   <= '0;
    end else if (acc) begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

### hw/rtl/pts_queue.sv
// Short queue of result groups between the front end and the output stage.
module pts_queue import pts_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  grp_t    wdata,
  input  logic    pop,
  output grp_t    rdata,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

### hw/rtl/pts_back.sv
// Output stage: takes result groups, sends one result beat per cycle unless stalled.
module pts_back import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  grp_t        head,
  input  q_stat_t     qs,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_token_length,
  output logic [8:0]  out_bad_char,
  output logic        out_last
);

  logic out_valid_r;
  logic idx_r;
  grp_t grp_r;
  res_t cur;
  logic fire, take;

  assign cur              = idx_r ? grp_r.r1 : grp_r.r0;
  assign out_valid        = out_valid_r;
  assign out_kind         = cur.kind;
  assign out_error_code   = cur.code;
  assign out_token_length = cur.len;
  assign out_bad_char     = cur.bad;
  assign out_last         = idx_r || !grp_r.second;

  assign fire = out_valid_r && !out_stall;
  assign take = !out_valid_r || (fire && out_last);
  assign pop  = take && !qs.empty;

  always_ff @(posedge clk) begin
    if (pop) grp_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else if (take) begin
      out_valid_r <= !qs.empty;
      idx_r       <= 1'b0;
    end else if (fire) begin
      idx_r <= 1'b1;
    end
  end

endmodule

### tb/pts_token_checker.sv
// Checker for the token scanner: predicts the tokens of each accepted byte and compares results.
module pts_token_checker import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [2:0]  out_error_code,
  input  logic [15:0] out_token_length,
  input  logic [8:0]  out_bad_char,
  input  logic        out_last,
  output int unsigned fail_count,
  output int unsigned tokens_owed
);

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [15:0] len;
    logic [8:0]  bad;
    logic        last;
  } token_t;

  scan_state_t scan_st  = ST_IDLE;
  kind_t       tok_kind = KIND_IDENT;
  logic [15:0] tok_len  = '0;
  token_t      expected_tokens[$];
  int unsigned errors   = 0;

  function automatic logic dec_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  function automatic logic hex_digit(logic [7:0] c);
    return dec_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic exp_mark(logic [7:0] c);
    return (c == CH_LOWER_E) || (c == CH_UPPER_E);
  endfunction

  function automatic scan_state_t extend(scan_state_t s, logic [7:0] c);
    scan_state_t n;
    n = ST_NONE;
    case (s)
      ST_ID: if (letter(c) || dec_digit(c)) n = ST_ID;
      ST_DEC: begin
        if (dec_digit(c)) n = ST_DEC;
        else if (c == CH_DOT) n = ST_FRAC;
        else if (exp_mark(c)) n = ST_EXPS;
      end
      ST_HEXS, ST_HEX: if (hex_digit(c)) n = ST_HEX;
      ST_OCTS, ST_OCT: if ((c >= CH_ZERO) && (c <= CH_SEVEN)) n = ST_OCT;
      ST_BINS, ST_BIN: if ((c == CH_ZERO) || (c == CH_ONE)) n = ST_BIN;
      ST_FRAC: begin
        if (dec_digit(c)) n = ST_FRAC;
        else if (exp_mark(c)) n = ST_EXPS;
      end
      ST_EXPS: begin
        if ((c == CH_PLUS) || (c == CH_MINUS)) n = ST_EXPSIGN;
        else if (dec_digit(c)) n = ST_EXP;
      end
      ST_EXPSIGN, ST_EXP: if (dec_digit(c)) n = ST_EXP;
      ST_STR: begin
        if (c == CH_QUOTE) n = ST_STRQ;
        else if (c != CH_NEWLINE) n = ST_STR;
      end
      ST_STRQ: begin
        if (c == CH_HASH) n = ST_CTRLS;
        else if (c == CH_QUOTE) n = ST_STR;
      end
      ST_CTRLS: if (dec_digit(c)) n = ST_CTRL;
      ST_CTRL: begin
        if (dec_digit(c)) n = ST_CTRL;
        else if (c == CH_HASH) n = ST_CTRLS;
        else if (c == CH_QUOTE) n = ST_STR;
      end
      default: n = ST_NONE;
    endcase
    return n;
  endfunction

  // States in which a token is still incomplete map to the error it would raise.
  function automatic err_t stuck_code(scan_state_t s);
    err_t e;
    case (s)
      ST_HEXS:             e = ERR_HEX;
      ST_OCTS:             e = ERR_OCT;
      ST_BINS:             e = ERR_BIN;
      ST_EXPS, ST_EXPSIGN: e = ERR_EXPONENT;
      ST_CTRLS:            e = ERR_CONTROL;
      ST_STR:              e = ERR_UNTERM;
      default:             e = ERR_NONE;
    endcase
    return e;
  endfunction

  function automatic token_t make_token(kind_t k, err_t e, logic [8:0] bad);
    token_t t;
    t.kind = k;
    t.code = e;
    t.len  = tok_len;
    t.bad  = bad;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic clear_token();
    scan_st  = ST_IDLE;
    tok_kind = KIND_IDENT;
    tok_len  = '0;
  endtask

  task automatic scan_byte(logic [7:0] c, logic eoi);
    token_t      beat_toks[2];
    int          n;
    scan_state_t nxt;
    err_t        code;
    logic        fresh;
    n = 0;
    if (eoi) begin
      if (scan_st != ST_IDLE) begin
        code = stuck_code(scan_st);
        if (code != ERR_NONE) beat_toks[n] = make_token(KIND_ERROR, code, BAD_EOI);
        else beat_toks[n] = make_token(tok_kind, ERR_NONE, 9'd0);
        n++;
      end
      clear_token();
    end else begin
      fresh = 1'b1;
      if (scan_st != ST_IDLE) begin
        nxt = extend(scan_st, c);
        if (nxt != ST_NONE) begin
          scan_st = nxt;
          if ((nxt == ST_FRAC) || (nxt == ST_EXPS)) tok_kind = KIND_FLOAT;
          if (tok_len != 16'hFFFF) tok_len++;
          fresh = 1'b0;
        end else begin
          code = stuck_code(scan_st);
          if (code != ERR_NONE) begin
            beat_toks[n] = make_token(KIND_ERROR, code, {1'b0, c});
            fresh = 1'b0;
          end else begin
            beat_toks[n] = make_token(tok_kind, ERR_NONE, 9'd0);
          end
          n++;
          clear_token();
        end
      end
      if (fresh) begin
        tok_len = 16'd1;
        if (letter(c)) begin
          scan_st = ST_ID;
          tok_kind = KIND_IDENT;
        end else if (dec_digit(c)) begin
          scan_st = ST_DEC;
          tok_kind = KIND_DEC;
        end else if (c == CH_DOLLAR) begin
          scan_st = ST_HEXS;
          tok_kind = KIND_HEX;
        end else if (c == CH_AMP) begin
          scan_st = ST_OCTS;
          tok_kind = KIND_OCT;
        end else if (c == CH_PERCENT) begin
          scan_st = ST_BINS;
          tok_kind = KIND_BIN;
        end else if ((c == CH_QUOTE) || (c == CH_HASH)) begin
          scan_st = (c == CH_QUOTE) ? ST_STR : ST_CTRLS;
          tok_kind = KIND_STRING;
        end else begin
          tok_len = '0;
          beat_toks[n] = make_token(KIND_ERROR, ERR_INVALID, {1'b0, c});
          n++;
          clear_token();
        end
      end
    end
    if (n > 0) beat_toks[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(beat_toks[i]);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      clear_token();
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("result beat with no token expected: kind %0d, length %0d",
                 out_kind, out_token_length);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("error_code", 16'(want.code), 16'(out_error_code));
          check_field("token_length", want.len, out_token_length);
          check_field("bad_char", 16'(want.bad), 16'(out_bad_char));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (in_valid && !in_stall) scan_byte(in_ch, in_end_of_input);
    end
    fail_count  <= errors;
    tokens_owed <= expected_tokens.size();
  end

endmodule

### tb/pascal_token_scanner_top_tb.sv
// Testbench top for the token scanner: clock, reset, byte stimulus, result stalls and verdict.
module pascal_token_scanner_top_tb;
  import pts_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned LONG_IDENT   = 48;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic [7:0]  in_ch           = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [2:0]  out_error_code;
  logic [15:0] out_token_length;
  logic [8:0]  out_bad_char;
  logic        out_last;

  int unsigned fail_count;
  int unsigned tokens_owed;
  logic        calm        = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent  = 0;

  always #6 clk = ~clk;

  pascal_token_scanner_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_token_length (out_token_length),
    .out_bad_char     (out_bad_char),
    .out_last         (out_last)
  );

  pts_token_checker token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_token_length (out_token_length),
    .out_bad_char     (out_bad_char),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .tokens_owed      (tokens_owed)
  );

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin : receiver
    int unsigned pause;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else if (out_valid && !out_stall) begin
      pause = pause_len();
      stall_left <= pause;
      out_stall <= (pause != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_dec();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(CH_ZERO + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  task automatic send_quoted();
    logic [7:0] c;
    send_beat(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
      end else begin
        do c = 8'($urandom_range(0, 255)); while ((c == CH_QUOTE) || (c == CH_NEWLINE));
        send_beat(c, 1'b0);
      end
    end
    send_beat(CH_QUOTE, 1'b0);
  endtask

  task automatic send_random_token();
    string seps;
    seps = " ;:,()+-*=<>[]@^{}\t\r";
    case ($urandom_range(0, 11))
      0, 1: begin
        send_beat(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 8))
          send_beat($urandom_range(0, 1) ? rand_letter() : rand_dec(), 1'b0);
      end
      2, 3: begin
        repeat ($urandom_range(1, 5)) send_beat(rand_dec(), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_beat(CH_DOT, 1'b0);
          repeat ($urandom_range(0, 4)) send_beat(rand_dec(), 1'b0);
        end
        if ($urandom_range(0, 1)) begin
          send_beat($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E, 1'b0);
          if ($urandom_range(0, 1)) send_beat($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
          repeat ($urandom_range(1, 3)) send_beat(rand_dec(), 1'b0);
        end
      end
      4: begin
        send_beat(CH_DOLLAR, 1'b0);
        repeat ($urandom_range(1, 6)) send_beat(rand_hex(), 1'b0);
      end
      5: begin
        send_beat(CH_AMP, 1'b0);
        repeat ($urandom_range(1, 6)) send_beat(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
      end
      6: begin
        send_beat(CH_PERCENT, 1'b0);
        repeat ($urandom_range(1, 6)) send_beat(CH_ZERO + 8'($urandom_range(0, 1)), 1'b0);
      end
      7, 8: begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 2) != 0) begin
            send_quoted();
          end else begin
            send_beat(CH_HASH, 1'b0);
            repeat ($urandom_range(1, 3)) send_beat(rand_dec(), 1'b0);
          end
        end
      end
      9: send_beat(seps[$urandom_range(0, seps.len() - 1)], 1'b0);
      10: begin
        case ($urandom_range(0, 5))
          0: send_beat(CH_DOLLAR, 1'b0);
          1: send_beat(CH_AMP, 1'b0);
          2: send_beat(CH_PERCENT, 1'b0);
          3: send_beat(CH_HASH, 1'b0);
          4: begin
            send_beat(rand_dec(), 1'b0);
            send_beat($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E, 1'b0);
            if ($urandom_range(0, 1)) send_beat($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
          end
          default: begin
            send_beat(CH_QUOTE, 1'b0);
            send_beat(rand_letter(), 1'b0);
          end
        endcase
        case ($urandom_range(0, 2))
          0: send_eoi();
          1: send_beat(CH_NEWLINE, 1'b0);
          default: send_beat(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      default: begin
        if ($urandom_range(0, 3) == 0) send_eoi();
        else send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    if ($urandom_range(0, 15) == 0) send_eoi();
  endtask

  initial begin : stimulus
    int unsigned random_end;
    logic        drained;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_text("_9$F&7%12.5e+1''''#9");
    send_beat(8'hFF, 1'b0);
    send_text("$g&8%2#x'\n1e");
    send_eoi();
    send_eoi();
    send_beat(8'h00, 1'b0);
    send_text("a");
    send_eoi();

    random_end = bytes_sent + RANDOM_BYTES;
    drained = 1'b0;
    while (bytes_sent < random_end) begin
      if ($urandom_range(0, 40) == 0) calm <= !calm;
      send_random_token();
      if (!drained && (bytes_sent > random_end - RANDOM_BYTES / 2)) begin
        wait_all_results();
        drained = 1'b1;
      end
    end

    // A long identifier arrives with no gaps between its beats.
    calm <= 1'b1;
    send_beat(rand_letter(), 1'b0);
    repeat (LONG_IDENT) send_beat(rand_letter(), 1'b0);
    send_beat(8'h20, 1'b0);
    calm <= 1'b0;
    send_text("_x");
    send_eoi();

    wait_all_results();
    repeat (20) @(posedge clk);
    if ((fail_count == 0) && (tokens_owed == 0)) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
